/* hw/rtl/wma_pkg.sv */
// wma_pkg: shared types and constants of the warm-up moving average core
// no dependencies; compile first

package wma_pkg;

  // default geometry
  localparam int unsigned WMA_WINDOW          = 16;
  localparam int unsigned WMA_SAMPLE_BITS     = 24;
  localparam int unsigned WMA_MAX_SAMPLE_BITS = 32;

  // fixed field widths of the channels
  localparam int unsigned WMA_MODE_BITS = 2;
  localparam int unsigned WMA_IN_BITS   = 24;
  localparam int unsigned WMA_OUT_BITS  = 24;

  // item kinds
  typedef enum logic [WMA_MODE_BITS-1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_REPORT  = 2'd1,
    MODE_RESTART = 2'd2
  } wma_mode_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ACC,
    ST_DIV,
    ST_DONE
  } wma_state_e;

  // input beat
  typedef struct packed {
    logic [WMA_MODE_BITS-1:0] mode;
    logic [WMA_IN_BITS-1:0]   sample_value;
  } wma_in_t;

  // output beat
  typedef struct packed {
    logic [WMA_OUT_BITS-1:0] average;
    logic                    empty_flag;
  } wma_out_t;

  // controls of the serial accumulator
  typedef struct packed {
    logic clear;
    logic load_new;
    logic load_old;
    logic sub;
    logic step;
  } wma_acc_ctrl_t;

  // controls of the serial divider
  typedef struct packed {
    logic load;
    logic step;
  } wma_div_ctrl_t;

endpackage

/* hw/rtl/wma_stream_if.sv */
// wma_stream_if: valid/ready channel carrying one payload beat
// payload type set per instance; no other dependencies

interface wma_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/warmup_moving_average_core.sv */
// warmup_moving_average_core: top level of the boxcar moving average with warm-up
// depends on wma_pkg, wma_stream_if, wma_ram, wma_acc, wma_div
//
//  port    dir   beat          handshake
//  in_i    sink  wma_in_t      valid/ready, taken when both high
//  out_o   src   wma_out_t     valid/ready, held until taken
//
// sample: ring read, then one bit of the sum per cycle
// report: one quotient bit per cycle; with no samples the division is skipped
// restart and unused codes: taken in ST_IDLE, the core stays idle
// SUM_BITS = SAMPLE_BITS + clog2(WINDOW + 1), 29 at the defaults
// reset clears count, index, sum and the output valid flag; the ring and the output data are not cleared
// a report waits in its last state while the output register is still full

module warmup_moving_average_core #(
  parameter int unsigned WINDOW      = wma_pkg::WMA_WINDOW,
  parameter int unsigned SAMPLE_BITS = wma_pkg::WMA_SAMPLE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wma_stream_if.sink   in_i,
  wma_stream_if.source out_o
);
  import wma_pkg::*;

  localparam int unsigned CNT_BITS  = $clog2(WINDOW + 1);
  localparam int unsigned IDX_BITS  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_BITS  = SAMPLE_BITS + CNT_BITS;
  localparam int unsigned STEP_BITS = $clog2(SUM_BITS);

  wma_state_e state_q, state_d;

  logic [CNT_BITS-1:0]  count_q, count_d;
  logic [IDX_BITS-1:0]  idx_q, idx_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic                 empty_q, empty_d;
  logic                 out_valid_q, out_valid_d;
  wma_out_t             out_beat_q;

  logic                           in_fire;
  wma_mode_e                      mode;
  logic                           window_full;
  logic                           out_free;
  logic                           load_out;
  logic [WMA_MAX_SAMPLE_BITS-1:0] sample_ext;
  logic [SAMPLE_BITS-1:0]         sample_val;
  logic [SAMPLE_BITS-1:0]         old_val;
  logic [SUM_BITS-1:0]            sum;
  logic [SUM_BITS-1:0]            quotient;
  logic [WMA_OUT_BITS-1:0]        mean;
  wma_acc_ctrl_t                  acc_ctrl;
  wma_div_ctrl_t                  div_ctrl;

  // input decode
  assign in_fire     = in_i.valid & in_i.ready;
  assign mode        = wma_mode_e'(in_i.payload.mode);
  assign window_full = (count_q == CNT_BITS'(WINDOW));
  assign out_free    = ~out_valid_q | out_o.ready;
  assign sample_ext  = WMA_MAX_SAMPLE_BITS'(in_i.payload.sample_value);
  assign sample_val  = sample_ext[SAMPLE_BITS-1:0];

  // sample ring, read and written at the same slot on a sample beat
  wma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW),
    .AW    (IDX_BITS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (acc_ctrl.load_new),
    .waddr_i (idx_q),
    .wdata_i (sample_val),
    .raddr_i (idx_q),
    .rdata_o (old_val)
  );

  wma_acc #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (acc_ctrl),
    .new_val_i (sample_val),
    .old_val_i (old_val),
    .sum_o     (sum)
  );

  wma_div #(
    .CNT_BITS (CNT_BITS),
    .SUM_BITS (SUM_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .ctrl_i     (div_ctrl),
    .dividend_i (sum),
    .divisor_i  (count_q),
    .quotient_o (quotient)
  );

  // saturate the mean to the output field
  generate
    if (SUM_BITS > WMA_OUT_BITS) begin : g_sat
      assign mean = (|quotient[SUM_BITS-1:WMA_OUT_BITS]) ? '1 : quotient[WMA_OUT_BITS-1:0];
    end else begin : g_nosat
      assign mean = WMA_OUT_BITS'(quotient);
    end
  endgenerate

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (mode)
            MODE_SAMPLE: state_d = ST_FETCH;
            MODE_REPORT: state_d = (count_q == '0) ? ST_DONE : ST_DIV;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_FETCH: state_d = ST_ACC;
      ST_ACC: begin
        if (step_q == '0) state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (step_q == '0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_i.ready        = (state_q == ST_IDLE);
    acc_ctrl.clear    = in_fire & (mode == MODE_RESTART);
    acc_ctrl.load_new = in_fire & (mode == MODE_SAMPLE);
    acc_ctrl.sub      = window_full;
    acc_ctrl.load_old = (state_q == ST_FETCH);
    acc_ctrl.step     = (state_q == ST_ACC);
    div_ctrl.load     = in_fire & (mode == MODE_REPORT);
    div_ctrl.step     = (state_q == ST_DIV);
    load_out          = (state_q == ST_DONE) & out_free;
  end

  // count, slot index, bit counter and empty flag
  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    empty_d = empty_q;
    if (acc_ctrl.clear) begin
      count_d = '0;
      idx_d   = '0;
    end else if (acc_ctrl.load_new) begin
      if (!window_full) count_d = count_q + CNT_BITS'(1);
      idx_d = (idx_q == IDX_BITS'(WINDOW - 1)) ? '0 : idx_q + IDX_BITS'(1);
    end
    if (div_ctrl.load) begin
      empty_d = (count_q == '0);
    end
    step_d = (acc_ctrl.step | div_ctrl.step) ? step_q - STEP_BITS'(1)
                                             : STEP_BITS'(SUM_BITS - 1);
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_beat_q.average    <= empty_q ? '0 : mean;
      out_beat_q.empty_flag <= empty_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_beat_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(WINDOW))
    else $error("sample count above window");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (count_q != '0))
    else $error("divide with zero sample count");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_ctrl.load_new && !window_full) |=> (count_q == $past(count_q) + CNT_BITS'(1)))
    else $error("sample count did not advance");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == ST_DONE))
    else $error("result beat without finished report");

endmodule

/* hw/rtl/wma_ram.sv */
// wma_ram: generic single write port ram with registered read
// no dependencies

module wma_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read (read returns old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/wma_acc.sv */
// wma_acc: bit-serial running sum, sum + new (- old when sub is set) one bit per cycle
// depends on wma_pkg

module wma_acc #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned SUM_BITS    = 29
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wma_pkg::wma_acc_ctrl_t       ctrl_i,
  input  logic [SAMPLE_BITS-1:0]       new_val_i,
  input  logic [SAMPLE_BITS-1:0]       old_val_i,
  output logic [SUM_BITS-1:0]          sum_o
);
  import wma_pkg::*;

  logic [SUM_BITS-1:0]    sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] new_q, new_d;
  logic [SAMPLE_BITS-1:0] old_q, old_d;
  logic [1:0]             carry_q, carry_d;
  logic                   sub_q, sub_d;
  logic [2:0]             total;

  // one column of sum + new + ~old + carry, ~old only when sub is set; old shifts in zeros so ~old sign-extends
  always_comb begin
    total = 3'(sum_q[0]) + 3'(new_q[0]) + 3'(sub_q & ~old_q[0]) + 3'(carry_q);
  end

  // operand shift registers
  always_comb begin
    new_d   = new_q;
    old_d   = old_q;
    sub_d   = sub_q;
    carry_d = carry_q;
    if (ctrl_i.load_new) begin
      new_d   = new_val_i;
      sub_d   = ctrl_i.sub;
      carry_d = 2'(ctrl_i.sub);
    end else if (ctrl_i.load_old) begin
      old_d = old_val_i;
    end else if (ctrl_i.step) begin
      new_d   = {1'b0, new_q[SAMPLE_BITS-1:1]};
      old_d   = {1'b0, old_q[SAMPLE_BITS-1:1]};
      carry_d = total[2:1];
    end
  end

  // sum rotates right, result bit enters at the top
  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.step) begin
      sum_d = {total[0], sum_q[SUM_BITS-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sub_q   <= 1'b0;
      carry_q <= '0;
    end else begin
      sum_q   <= sum_d;
      sub_q   <= sub_d;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    old_q <= old_d;
  end

  assign sum_o = sum_q;

endmodule

/* hw/rtl/wma_div.sv */
// wma_div: restoring divider, one quotient bit per cycle, msb first
// depends on wma_pkg

module wma_div #(
  parameter int unsigned CNT_BITS = 5,
  parameter int unsigned SUM_BITS = 29
) (
  input  logic                   clk_i,
  input  wma_pkg::wma_div_ctrl_t ctrl_i,
  input  logic [SUM_BITS-1:0]    dividend_i,
  input  logic [CNT_BITS-1:0]    divisor_i,
  output logic [SUM_BITS-1:0]    quotient_o
);
  import wma_pkg::*;

  logic [SUM_BITS-1:0] dvd_q, dvd_d;
  logic [CNT_BITS-1:0] rem_q, rem_d;
  logic [CNT_BITS:0]   trial;
  logic [CNT_BITS:0]   diff;
  logic                fits;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {rem_q, dvd_q[SUM_BITS-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = (trial >= {1'b0, divisor_i});
  end

  // dividend shifts out at the top, quotient bits enter at the bottom
  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    if (ctrl_i.load) begin
      dvd_d = dividend_i;
      rem_d = '0;
    end else if (ctrl_i.step) begin
      dvd_d = {dvd_q[SUM_BITS-2:0], fits};
      rem_d = fits ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign quotient_o = dvd_q;

endmodule
